[sv/cal_pkg.sv]
`default_nettype none

package cal_pkg;

	localparam int IDX_W    = 6;
	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 7;
	// reads reach only the positions an index can name
	localparam int IDX_SPAN = 1 << IDX_W;
	// cells folded into one partial word in the first read stage
	localparam int GRP_SIZE = 8;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_SET    = 2'd1,
		OP_GET    = 2'd2,
		OP_DELETE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		op_t                       op;
		logic [IDX_W-1:0]          index;
		logic signed [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] read_value;
		logic [COUNT_W-1:0]        count;
		status_t                   status;
	} rsp_t;

	// broadcast from the decoder to every cell; each flag already carries
	// the range check and the stage advance
	typedef struct packed {
		logic             do_append;
		logic             do_set;
		logic             do_delete;
		logic             do_get;
		logic [IDX_W-1:0] index;
	} cell_ctrl_t;

endpackage

`default_nettype wire

[sv/cal_cell.sv]
`default_nettype none

module cal_cell
	import cal_pkg::*;
#(
	parameter int DATA_WIDTH = 32,
	parameter int CNT_W      = 7,
	parameter int POS_W      = 7,
	parameter int POS        = 0
) (
	input  wire logic                  clk,
	input  wire cell_ctrl_t            ctrl,
	input  wire logic [CNT_W-1:0]      count,
	input  wire logic [DATA_WIDTH-1:0] value,
	input  wire logic [DATA_WIDTH-1:0] next_data,
	output logic      [DATA_WIDTH-1:0] data,
	output logic      [DATA_WIDTH-1:0] rd_word
);

	localparam logic [POS_W:0] POS_V = (POS_W + 1)'(POS);
	localparam logic [POS_W:0] POS_N = (POS_W + 1)'(POS + 1);

	logic [DATA_WIDTH-1:0] data_q;
	logic [DATA_WIDTH-1:0] data_d;
	logic                  load;
	logic [POS_W:0]        idx_ext;
	logic [POS_W:0]        cnt_ext;

	assign idx_ext = (POS_W + 1)'(ctrl.index);
	assign cnt_ext = (POS_W + 1)'(count);

	always_comb begin
		load   = 1'b0;
		data_d = value;
		priority if (ctrl.do_append && cnt_ext == POS_V) begin
			load = 1'b1;
		end else if (ctrl.do_set && idx_ext == POS_V) begin
			load = 1'b1;
		end else if (ctrl.do_delete && POS_V >= idx_ext && POS_N < cnt_ext) begin
			// take the upper neighbor to close the gap
			load   = 1'b1;
			data_d = next_data;
		end else begin
			load = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= data_d;
		end
	end

	assign data    = data_q;
	assign rd_word = (ctrl.do_get && idx_ext == POS_V) ? data_q : '0;

endmodule

`default_nettype wire

[sv/compacting_array_list.sv]
`default_nettype none

// channel  dir  payload  transfer when
// req      in   req_t    req_valid && req_ready
// rsp      out  rsp_t    rsp_valid && rsp_ready
//
// Each op passes the input register, the cell row (cell update with partial read OR)
// and the final OR into the result register before its result appears.
// A new request is taken every cycle while rsp_ready stays high; the pipeline
// stages fill behind a stalled result and req_ready drops only when all are full.
// Reset clears the count and the stage valids; cell contents are left as is.

module compacting_array_list
	import cal_pkg::*;
#(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int POS_W      = (CNT_W > IDX_W) ? CNT_W : IDX_W;
	localparam int READ_CELLS = (CAPACITY < IDX_SPAN) ? CAPACITY : IDX_SPAN;
	localparam int NGRP       = (READ_CELLS + GRP_SIZE - 1) / GRP_SIZE;
	localparam logic [CNT_W-1:0] CAP_V = CNT_W'(CAPACITY);

	// stage valids and stage enables
	logic valid_s1, valid_s2, rsp_valid_q;
	logic en_out, en_s2, en_s1, advance;

	req_t             item_s1;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	status_t          status_d;
	logic             in_range, full;
	cell_ctrl_t       ctrl;
	logic [DATA_WIDTH-1:0] value_ext;

	logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
	logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];
	logic [DATA_WIDTH-1:0] part_d    [NGRP];
	logic [DATA_WIDTH-1:0] part_s2   [NGRP];
	logic [CNT_W-1:0]      count_s2;
	status_t               status_s2;
	logic [DATA_WIDTH-1:0] rd_word;
	logic [VALUE_W-1:0]    rd_value;
	rsp_t                  rsp_q;

	assign en_out    = !rsp_valid_q || rsp_ready;
	assign en_s2     = !valid_s2 || en_out;
	assign en_s1     = !valid_s1 || en_s2;
	assign req_ready = en_s1;
	assign advance   = valid_s1 && en_s2;

	// decode against the count left by all earlier items
	assign in_range = POS_W'(item_s1.index) < POS_W'(count_q);
	assign full     = count_q == CAP_V;

	always_comb begin
		ctrl          = '0;
		ctrl.index    = item_s1.index;
		count_d       = count_q;
		status_d      = STAT_OK;
		unique case (item_s1.op)
			OP_APPEND: begin
				if (full) begin
					status_d = STAT_FULL;
				end else begin
					ctrl.do_append = advance;
					count_d        = count_q + 1'b1;
				end
			end
			OP_SET: begin
				if (!in_range) status_d = STAT_RANGE;
				else ctrl.do_set = advance;
			end
			OP_GET: begin
				if (!in_range) status_d = STAT_RANGE;
				else ctrl.do_get = advance;
			end
			OP_DELETE: begin
				if (!in_range) begin
					status_d = STAT_RANGE;
				end else begin
					ctrl.do_delete = advance;
					count_d        = count_q - 1'b1;
				end
			end
			default: status_d = STAT_OK;
		endcase
	end

	generate
		if (DATA_WIDTH <= VALUE_W) begin : g_val_narrow
			assign value_ext = item_s1.value[DATA_WIDTH-1:0];
		end else begin : g_val_wide
			assign value_ext = {{(DATA_WIDTH - VALUE_W){item_s1.value[VALUE_W-1]}},
				item_s1.value};
		end
	endgenerate

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] upper;
		if (i == CAPACITY - 1) begin : g_last
			assign upper = '0;
		end else begin : g_mid
			assign upper = cell_data[i+1];
		end
		cal_cell #(
			.DATA_WIDTH(DATA_WIDTH),
			.CNT_W     (CNT_W),
			.POS_W     (POS_W),
			.POS       (i)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.count    (count_q),
			.value    (value_ext),
			.next_data(upper),
			.data     (cell_data[i]),
			.rd_word  (cell_rd[i])
		);
	end

	// first read stage: fold groups of cells into partial words
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			part_d[g] = '0;
			for (int k = 0; k < GRP_SIZE; k++) begin
				if (g * GRP_SIZE + k < READ_CELLS) begin
					part_d[g] = part_d[g] | cell_rd[g*GRP_SIZE+k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			rsp_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (en_s1) valid_s1 <= req_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_out) rsp_valid_q <= valid_s2;
			if (advance) count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && req_valid) begin
			item_s1 <= req;
		end
		if (advance) begin
			part_s2   <= part_d;
			count_s2  <= count_d;
			status_s2 <= status_d;
		end
		if (en_out && valid_s2) begin
			rsp_q.read_value <= rd_value;
			rsp_q.count      <= COUNT_W'(count_s2);
			rsp_q.status     <= status_s2;
		end
	end

	// second read stage: combine the partials
	always_comb begin
		rd_word = '0;
		for (int g = 0; g < NGRP; g++) begin
			rd_word = rd_word | part_s2[g];
		end
	end

	generate
		if (DATA_WIDTH >= VALUE_W) begin : g_rd_wide
			assign rd_value = rd_word[VALUE_W-1:0];
		end else begin : g_rd_narrow
			assign rd_value = {{(VALUE_W - DATA_WIDTH){rd_word[DATA_WIDTH-1]}}, rd_word};
		end
	endgenerate

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_V)
		else $error("entry count above capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == $past(count_q) || count_q == CNT_W'($past(count_q) + 1'b1)
		|| count_q == CNT_W'($past(count_q) - 1'b1))
		else $error("entry count moved by more than one");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> count_q == $past(count_q))
		else $error("entry count changed without an item in the cells");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STAT_FULL |-> rsp.count == COUNT_W'(CAPACITY))
		else $error("full status while list not at capacity");

	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.read_value != '0 |-> rsp.status == STAT_OK)
		else $error("read data returned with an error status");

endmodule

`default_nettype wire

[dv/cal_list_checker.sv]
module cal_list_checker
	import cal_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	input  wire logic req_ready,
	input  wire req_t req,
	input  wire logic rsp_valid,
	input  wire logic rsp_ready,
	input  wire rsp_t rsp,
	output int        mismatches,
	output int        results_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	logic signed [VALUE_W-1:0] slots [CAPACITY];
	int                        used;
	int                        bad;
	rsp_t                      rsp_due [$];

	// apply one list operation to the shadow list and return its result
	function automatic rsp_t apply_list_op(input req_t r);
		rsp_t res;
		int   pos;
		res.read_value = '0;
		res.count      = '0;
		res.status     = STAT_OK;
		pos            = int'(r.index);
		case (r.op)
			OP_APPEND: begin
				if (used >= CAPACITY) begin
					res.status = STAT_FULL;
				end else begin
					slots[used] = r.value;
					used++;
				end
			end
			OP_SET: begin
				if (pos >= used || pos >= CAPACITY) begin
					res.status = STAT_RANGE;
				end else begin
					slots[pos] = r.value;
				end
			end
			OP_GET: begin
				if (pos >= used || pos >= CAPACITY) begin
					res.status = STAT_RANGE;
				end else begin
					res.read_value = slots[pos];
				end
			end
			OP_DELETE: begin
				if (pos >= used || pos >= CAPACITY) begin
					res.status = STAT_RANGE;
				end else begin
					// close the gap: shift every higher entry down one place
					for (int i = pos; i + 1 < used; i++) begin
						slots[i] = slots[i + 1];
					end
					used--;
				end
			end
		endcase
		res.count = COUNT_W'(used);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t due;
		if (!arst_n) begin
			used = 0;
			bad  = 0;
			rsp_due.delete();
			mismatches   <= 0;
			results_owed <= 0;
		end else begin
			// a result never belongs to a request taken at the same edge
			if (rsp_valid && rsp_ready) begin
				if (rsp_due.size() == 0) begin
					$error("result transfer with no request outstanding: read_value %0d count %0d status %0d",
						rsp.read_value, rsp.count, rsp.status);
					bad++;
				end else begin
					due = rsp_due.pop_front();
					if (rsp.read_value !== due.read_value) begin
						$error("read_value expected %0d actual %0d", due.read_value, rsp.read_value);
						bad++;
					end
					if (rsp.count !== due.count) begin
						$error("count expected %0d actual %0d", due.count, rsp.count);
						bad++;
					end
					if (rsp.status !== due.status) begin
						$error("status expected %0d actual %0d", due.status, rsp.status);
						bad++;
					end
				end
			end
			if (req_valid && req_ready) begin
				rsp_due.push_back(apply_list_op(req));
			end
			mismatches   <= bad;
			results_owed <= rsp_due.size();
		end
	end

endmodule

[dv/compacting_array_list_tb.sv]
module compacting_array_list_tb;
	import cal_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY    = 64;
	localparam int STALL_LIMIT = 1000;
	localparam int BLOCKS      = 20;
	localparam int BLOCK_LEN   = 100;
	localparam int HOLD_AT     = 600;
	localparam int HOLD_CYCLES = 80;
	// op mix per traffic mode: fill, drain, mixed (cumulative percent)
	localparam int APPEND_PCT [3] = '{70, 15, 30};
	localparam int SET_PCT    [3] = '{80, 25, 50};
	localparam int GET_PCT    [3] = '{92, 40, 75};

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	int   err_count;
	int   results_owed;
	int   fill_est     = 0;
	int   quiet_cycles = 0;
	bit   steady       = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	compacting_array_list #(
		.CAPACITY  (CAPACITY),
		.DATA_WIDTH(VALUE_W)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	cal_list_checker #(
		.CAPACITY(CAPACITY)
	) i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.mismatches  (err_count),
		.results_owed(results_owed)
	);

	// offer one operation and hold it until the transfer
	task automatic offer(input op_t op, input logic [IDX_W-1:0] idx,
			input logic signed [VALUE_W-1:0] val);
		req_t item;
		int   gap;
		item.op    = op;
		item.index = idx;
		item.value = val;
		gap = steady ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		// rough occupancy, only to steer indexes toward live entries
		if (op == OP_APPEND && fill_est < CAPACITY) fill_est++;
		if (op == OP_DELETE && int'(idx) < fill_est) fill_est--;
	endtask

	initial begin
		int                        mode;
		int                        roll;
		op_t                       kind;
		logic [IDX_W-1:0]          pick;
		logic signed [VALUE_W-1:0] word;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list: every indexed op is out of range; then appends, sets, gets and deletes, some out of range
		offer(OP_GET,    '0, '0);
		offer(OP_SET,    '0, 32'sh1234_5678);
		offer(OP_DELETE, '0, '0);
		offer(OP_APPEND, '0, 32'sh7FFF_FFFF);
		offer(OP_APPEND, '1, 32'sh8000_0000);
		offer(OP_APPEND, '0, '0);
		offer(OP_APPEND, '0, '1);
		offer(OP_APPEND, '0, 32'sh5555_5555);
		for (int i = 0; i < 4; i++) offer(OP_GET, IDX_W'(i), '0);
		offer(OP_SET,    6'd2, 32'shAAAA_AAAA);
		offer(OP_GET,    6'd2, '0);
		offer(OP_DELETE, 6'd1, '0);
		offer(OP_GET,    6'd1, '0);
		offer(OP_DELETE, 6'd3, '0);
		offer(OP_GET,    '1, '0);
		offer(OP_SET,    '1, '1);
		offer(OP_DELETE, '1, '0);
		offer(OP_DELETE, '0, '0);
		offer(OP_GET,    '0, '0);

		for (int blk = 0; blk < BLOCKS; blk++) begin
			mode   = $urandom_range(0, 2);
			steady = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < BLOCK_LEN; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < APPEND_PCT[mode]) kind = OP_APPEND;
				else if (roll < SET_PCT[mode]) kind = OP_SET;
				else if (roll < GET_PCT[mode]) kind = OP_GET;
				else kind = OP_DELETE;
				if (fill_est > 0 && $urandom_range(0, 6) != 0)
					pick = IDX_W'($urandom_range(0, fill_est - 1));
				else
					pick = IDX_W'($urandom_range(0, IDX_SPAN - 1));
				if ($urandom_range(0, 4) == 0) begin
					case ($urandom_range(0, 3))
						0:       word = '0;
						1:       word = '1;
						2:       word = 32'sh8000_0000;
						default: word = 32'sh7FFF_FFFF;
					endcase
				end else begin
					word = $urandom;
				end
				offer(kind, pick, word);
			end
		end
		req_valid <= 1'b0;
		steady    <= 1'b0;

		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("compacting_array_list_tb: PASS");
		else
			$display("compacting_array_list_tb: FAIL");
		$finish;
	end

	// result side: random stalls, one long hold-off to back the pipeline up
	initial begin
		int stall;
		int taken;
		taken = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 4);
			if (taken == HOLD_AT) stall = HOLD_CYCLES;
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
			taken++;
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("compacting_array_list_tb: FAIL");
			$finish;
		end
	end

endmodule
